[design/tcprff_pkg.sv]
// Shared constants, types and codes of the TCP receive frame filter.
package tcprff_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_LOCAL_PORT  = 2'd1;
    localparam logic [1:0] REG_REMOTE_PORT = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP          = 8'd6;
    localparam logic [15:0] DEFAULT_LOCAL_PORT = 16'd49153;
    localparam int          ETH_HDR_BYTES      = 14;
    localparam int          TCP_BASE_BYTES     = 20;
    localparam int          MIN_FRAME          = 14 + 20 + 20;
    localparam logic [3:0]  MIN_HDR_WORDS      = 4'd5;

    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_IHL      = 14;
    localparam int POS_TLEN_HI  = 16;
    localparam int POS_TLEN_LO  = 17;
    localparam int POS_PROTO    = 23;
    localparam int POS_DST_LO   = 30;
    localparam int POS_DST_HI   = 33;

    localparam int TCP_SPORT_END = 2;
    localparam int TCP_DPORT_END = 4;
    localparam int TCP_SEQ_END   = 8;
    localparam int TCP_ACK_END   = 12;
    localparam int TCP_OFFSET    = 12;
    localparam int TCP_FLAGS     = 13;

    localparam int OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_SHORT    = 3'd1,
        RSN_NOT_IPV4 = 3'd2,
        RSN_NOT_TCP  = 3'd3,
        RSN_DST_IP   = 3'd4,
        RSN_HEADER   = 3'd5,
        RSN_DST_PORT = 3'd6,
        RSN_SRC_PORT = 3'd7
    } t_reason;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      ether_type;
        logic [7:0]       ip_protocol;
        logic [3:0]       ip_header_words;
        logic [15:0]      ip_total_length;
        logic [31:0]      ip_destination;
        logic [15:0]      tcp_sport;
        logic [15:0]      tcp_dport;
        logic [31:0]      sequence_nr;
        logic [31:0]      ack_nr;
        logic [3:0]       tcp_header_words;
        logic [7:0]       flags;
    } t_frame;

    typedef struct packed {
        logic        accepted;
        t_reason     reason;
        logic [7:0]  tcp_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
    } t_result;

endpackage

[design/tcprff_capture.sv]
// Per-byte header capture and running frame state.
module tcprff_capture
    import tcprff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_frame     o_next
);

    t_frame           r_frame;
    t_frame           n_frame;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] tcp_start;
    logic [CNT_W-1:0] rel;

    always_comb begin
        pos       = r_frame.count;
        tcp_start = CNT_W'(ETH_HDR_BYTES) + {{(CNT_W-6){1'b0}}, r_frame.ip_header_words, 2'b00};
        rel       = pos - tcp_start;
        n_frame   = r_frame;
        if (pos < CNT_W'(MAX_FRAME_BYTES)) begin
            n_frame.count = pos + CNT_W'(1);
            if (pos == CNT_W'(POS_ETYPE_HI) || pos == CNT_W'(POS_ETYPE_LO)) begin
                n_frame.ether_type = {r_frame.ether_type[7:0], i_byte};
            end else if (pos == CNT_W'(POS_IHL)) begin
                n_frame.ip_header_words = i_byte[3:0];
            end else if (pos == CNT_W'(POS_TLEN_HI) || pos == CNT_W'(POS_TLEN_LO)) begin
                n_frame.ip_total_length = {r_frame.ip_total_length[7:0], i_byte};
            end else if (pos == CNT_W'(POS_PROTO)) begin
                n_frame.ip_protocol = i_byte;
            end else if (pos >= CNT_W'(POS_DST_LO) && pos <= CNT_W'(POS_DST_HI)) begin
                n_frame.ip_destination = {r_frame.ip_destination[23:0], i_byte};
            end
            if (pos > CNT_W'(POS_IHL) && r_frame.ip_header_words >= MIN_HDR_WORDS
                    && pos >= tcp_start) begin
                if (rel < CNT_W'(TCP_SPORT_END)) begin
                    n_frame.tcp_sport = {r_frame.tcp_sport[7:0], i_byte};
                end else if (rel < CNT_W'(TCP_DPORT_END)) begin
                    n_frame.tcp_dport = {r_frame.tcp_dport[7:0], i_byte};
                end else if (rel < CNT_W'(TCP_SEQ_END)) begin
                    n_frame.sequence_nr = {r_frame.sequence_nr[23:0], i_byte};
                end else if (rel < CNT_W'(TCP_ACK_END)) begin
                    n_frame.ack_nr = {r_frame.ack_nr[23:0], i_byte};
                end else if (rel == CNT_W'(TCP_OFFSET)) begin
                    n_frame.tcp_header_words = i_byte[7:4];
                end else if (rel == CNT_W'(TCP_FLAGS)) begin
                    n_frame.flags = i_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_take) begin
            r_frame <= i_last ? '0 : n_frame;
        end
    end

    assign o_next = n_frame;

endmodule

[design/tcprff_verdict.sv]
// Frame checks in priority order and result field computation.
module tcprff_verdict
    import tcprff_pkg::*;
(
    input  t_frame      i_frame,
    input  logic [31:0] i_local_ip,
    input  logic [15:0] i_local_port,
    input  logic [15:0] i_remote_port,
    output t_result     o_result
);

    logic [5:0]       ihl_bytes;
    logic [5:0]       thl_bytes;
    logic [CNT_W-1:0] need_len;
    logic [15:0]      seg_bytes;
    logic [15:0]      data_len;
    t_reason          reason;

    always_comb begin
        ihl_bytes = {i_frame.ip_header_words, 2'b00};
        thl_bytes = {i_frame.tcp_header_words, 2'b00};
        need_len  = CNT_W'(ETH_HDR_BYTES + TCP_BASE_BYTES) + {{(CNT_W-6){1'b0}}, ihl_bytes};
        seg_bytes = (i_frame.ip_total_length > {10'd0, ihl_bytes})
                  ? i_frame.ip_total_length - {10'd0, ihl_bytes} : 16'd0;
        data_len  = (seg_bytes > {10'd0, thl_bytes}) ? seg_bytes - {10'd0, thl_bytes} : 16'd0;

        if (i_frame.count < CNT_W'(MIN_FRAME)) begin
            reason = RSN_SHORT;
        end else if (i_frame.ether_type != ETHERTYPE_IPV4) begin
            reason = RSN_NOT_IPV4;
        end else if (i_frame.ip_protocol != PROTO_TCP) begin
            reason = RSN_NOT_TCP;
        end else if (i_frame.ip_destination != i_local_ip) begin
            reason = RSN_DST_IP;
        end else if (i_frame.ip_header_words < MIN_HDR_WORDS || i_frame.count < need_len) begin
            reason = RSN_HEADER;
        end else if (i_frame.tcp_dport != i_local_port) begin
            reason = RSN_DST_PORT;
        end else if (i_frame.tcp_sport != i_remote_port) begin
            reason = RSN_SRC_PORT;
        end else begin
            reason = RSN_OK;
        end

        o_result        = '0;
        o_result.reason = reason;
        if (reason == RSN_OK) begin
            o_result.accepted       = 1'b1;
            o_result.tcp_flags      = i_frame.flags;
            o_result.seq_number     = i_frame.sequence_nr;
            o_result.ack_number     = i_frame.ack_nr;
            o_result.payload_offset = 8'(ETH_HDR_BYTES) + {2'b00, ihl_bytes}
                                    + {2'b00, thl_bytes};
            o_result.payload_length = data_len;
        end
    end

endmodule

[design/tcp_receive_frame_filter.sv]
// Top level of the TCP receive frame filter: config registers, staging and output register.
//
//  channel   | direction | handshake             | content
//  s_axis    | in        | tvalid/tready         | tdata = frame byte, tlast = last byte
//  m_axis    | out       | tvalid/tready         | tuser = accepted, tdata = verdict and fields
//  apb       | in        | psel/penable, pready  | local_ip, local_port, remote_port
//
// One byte per cycle while s_axis_tready is high. After the last byte the finished
// frame state is staged, then checked into the output register.
// Reset is synchronous, clears frame state and valid flags and sets the config to defaults.
// s_axis_tready drops only while both the staged frame and the output register are full.
module tcp_receive_frame_filter
    import tcprff_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] frame_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] reject_reason, [10:3] tcp_flags,
                                                   // [42:11] seq_number, [74:43] ack_number,
                                                   // [82:75] payload_offset,
                                                   // [98:83] payload_length, [103:99] zero
    output logic                   m_axis_tuser,   // [0] accepted
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [31:0] r_local_ip;
    logic [15:0] r_local_port;
    logic [15:0] r_remote_port;
    t_frame      r_fin;
    logic        r_fin_valid;
    t_result     r_out;
    logic        r_out_valid;
    t_frame      n_frame;
    t_result     n_result;
    logic        take;
    logic        fin_move;
    logic        cfg_wr;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = !r_fin_valid || !r_out_valid;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign fin_move      = r_fin_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= '0;
            r_local_port  <= DEFAULT_LOCAL_PORT;
            r_remote_port <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LOCAL_IP:    r_local_ip    <= pwdata;
                REG_LOCAL_PORT:  r_local_port  <= pwdata[15:0];
                REG_REMOTE_PORT: r_remote_port <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOCAL_IP:    prdata = r_local_ip;
            REG_LOCAL_PORT:  prdata = {16'd0, r_local_port};
            REG_REMOTE_PORT: prdata = {16'd0, r_remote_port};
            default:         prdata = '0;
        endcase
    end

    tcprff_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_next  (n_frame)
    );

    tcprff_verdict u_verdict (
        .i_frame       (r_fin),
        .i_local_ip    (r_local_ip),
        .i_local_port  (r_local_port),
        .i_remote_port (r_remote_port),
        .o_result      (n_result)
    );

    // stage finished frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (take && s_axis_tlast) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && s_axis_tlast) begin
            r_fin <= n_frame;
        end
    end

    // hold verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.accepted;
    assign m_axis_tdata  = {5'd0, r_out.payload_length, r_out.payload_offset,
                            r_out.ack_number, r_out.seq_number, r_out.tcp_flags,
                            r_out.reason};

    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.accepted |-> r_out.reason == RSN_OK)
        else $error("accepted verdict carries a reject reason");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.accepted |->
            r_out.reason != RSN_OK && r_out.seq_number == '0 && r_out.ack_number == '0
            && r_out.payload_length == '0 && r_out.payload_offset == '0)
        else $error("rejected verdict carries segment fields");

    a_last_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && s_axis_tlast |=> r_fin_valid)
        else $error("last byte did not stage a frame");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_out_valid) |-> $past(m_axis_tready))
        else $error("verdict dropped without being taken");

endmodule

[tb/sv/tcp_receive_frame_filter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the TCP receive frame filter: byte-level frame requests, verdict checks.
module tcp_receive_frame_filter_tb;
    import tcprff_pkg::*;

    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 4_000_000;

    typedef struct {
        int          len;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] tlen;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  off_byte;
        logic [7:0]  flags;
        bit          typed;
        t_reason     want;
    } frame_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;   // [7:0] frame_byte
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;            // [2:0] reject_reason, [10:3] tcp_flags,
                                                     // [42:11] seq_number, [74:43] ack_number,
                                                     // [82:75] payload_offset,
                                                     // [98:83] payload_length
    logic                   m_axis_tuser;            // [0] accepted
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [ADDR_W-1:0]      paddr   = '0;
    logic [DATA_W-1:0]      pwdata  = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    t_frame      fr = '0;
    logic [31:0] cfg_ip    = 32'h0;
    logic [15:0] cfg_lport = DEFAULT_LOCAL_PORT;
    logic [15:0] cfg_rport = 16'h0;

    t_result     verdicts_q[$];
    t_result     due;
    logic [7:0]  frame_buf[];
    int          mismatches  = 0;
    int          tx_idle_pct = 6;
    int          rx_idle_pct = 53;
    bit          hold_go     = 1'b0;
    logic        rx_hold     = 1'b0;

    tcp_receive_frame_filter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    function automatic void absorb_byte(input logic [7:0] b);
        int pos;
        int rel;
        pos = int'(fr.count);
        if (pos >= MAX_FRAME_BYTES)
            return;
        fr.count = fr.count + CNT_W'(1);
        if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO)
            fr.ether_type = {fr.ether_type[7:0], b};
        else if (pos == POS_IHL)
            fr.ip_header_words = b[3:0];
        else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO)
            fr.ip_total_length = {fr.ip_total_length[7:0], b};
        else if (pos == POS_PROTO)
            fr.ip_protocol = b;
        else if (pos >= POS_DST_LO && pos <= POS_DST_HI)
            fr.ip_destination = {fr.ip_destination[23:0], b};
        if (pos <= POS_IHL || fr.ip_header_words < MIN_HDR_WORDS)
            return;
        rel = pos - ETH_HDR_BYTES - 4 * int'(fr.ip_header_words);
        if (rel < 0)
            return;
        if (rel < TCP_SPORT_END)
            fr.tcp_sport = {fr.tcp_sport[7:0], b};
        else if (rel < TCP_DPORT_END)
            fr.tcp_dport = {fr.tcp_dport[7:0], b};
        else if (rel < TCP_SEQ_END)
            fr.sequence_nr = {fr.sequence_nr[23:0], b};
        else if (rel < TCP_ACK_END)
            fr.ack_nr = {fr.ack_nr[23:0], b};
        else if (rel == TCP_OFFSET)
            fr.tcp_header_words = b[7:4];
        else if (rel == TCP_FLAGS)
            fr.flags = b;
    endfunction

    function automatic t_result frame_verdict();
        t_result r;
        int len;
        int ihlb;
        int thlb;
        int seg_bytes;
        int dlen;
        len  = int'(fr.count);
        ihlb = 4 * int'(fr.ip_header_words);
        thlb = 4 * int'(fr.tcp_header_words);
        r = '0;
        if (len < MIN_FRAME)
            r.reason = RSN_SHORT;
        else if (fr.ether_type != ETHERTYPE_IPV4)
            r.reason = RSN_NOT_IPV4;
        else if (fr.ip_protocol != PROTO_TCP)
            r.reason = RSN_NOT_TCP;
        else if (fr.ip_destination != cfg_ip)
            r.reason = RSN_DST_IP;
        else if (fr.ip_header_words < MIN_HDR_WORDS
                 || len < ETH_HDR_BYTES + ihlb + TCP_BASE_BYTES)
            r.reason = RSN_HEADER;
        else if (fr.tcp_dport != cfg_lport)
            r.reason = RSN_DST_PORT;
        else if (fr.tcp_sport != cfg_rport)
            r.reason = RSN_SRC_PORT;
        else begin
            seg_bytes = (int'(fr.ip_total_length) > ihlb) ? int'(fr.ip_total_length) - ihlb : 0;
            dlen      = (seg_bytes > thlb) ? seg_bytes - thlb : 0;
            r.reason         = RSN_OK;
            r.accepted       = 1'b1;
            r.tcp_flags      = fr.flags;
            r.seq_number     = fr.sequence_nr;
            r.ack_number     = fr.ack_nr;
            r.payload_offset = 8'(ETH_HDR_BYTES + ihlb + thlb);
            r.payload_length = 16'(dlen);
        end
        fr = '0;
        return r;
    endfunction

    always @(posedge i_clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_q.size() == 0) begin
                report_mismatch("verdict without a frame", {31'b0, m_axis_tuser}, 32'b0);
            end else begin
                due = verdicts_q.pop_front();
                if (m_axis_tuser != due.accepted)
                    report_mismatch("accepted", {31'b0, m_axis_tuser}, {31'b0, due.accepted});
                if (m_axis_tdata[2:0] != due.reason)
                    report_mismatch("reject_reason", {29'b0, m_axis_tdata[2:0]},
                                    {29'b0, due.reason});
                if (m_axis_tdata[10:3] != due.tcp_flags)
                    report_mismatch("tcp_flags", {24'b0, m_axis_tdata[10:3]},
                                    {24'b0, due.tcp_flags});
                if (m_axis_tdata[42:11] != due.seq_number)
                    report_mismatch("seq_number", m_axis_tdata[42:11], due.seq_number);
                if (m_axis_tdata[74:43] != due.ack_number)
                    report_mismatch("ack_number", m_axis_tdata[74:43], due.ack_number);
                if (m_axis_tdata[82:75] != due.payload_offset)
                    report_mismatch("payload_offset", {24'b0, m_axis_tdata[82:75]},
                                    {24'b0, due.payload_offset});
                if (m_axis_tdata[98:83] != due.payload_length)
                    report_mismatch("payload_length", {16'b0, m_axis_tdata[98:83]},
                                    {16'b0, due.payload_length});
            end
        end
    end

    task automatic drive_byte(input logic [7:0] b, input bit lst, input bit typed,
                              input t_reason want);
        t_result v;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_byte(b);
        if (lst) begin
            v = frame_verdict();
            if (typed) begin
                v = '0;
                v.reason = want;
            end
            verdicts_q.push_back(v);
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic void put(input int pos, input logic [7:0] v);
        if (pos < frame_buf.size())
            frame_buf[pos] = v;
    endfunction

    task automatic send_frame(input frame_row s);
        int t;
        frame_buf = new[s.len];
        foreach (frame_buf[i])
            frame_buf[i] = 8'($urandom);
        t = (s.ver_ihl[3:0] >= MIN_HDR_WORDS) ? ETH_HDR_BYTES + 4 * int'(s.ver_ihl[3:0])
                                              : ETH_HDR_BYTES + 20;
        put(POS_ETYPE_HI, s.etype[15:8]);
        put(POS_ETYPE_LO, s.etype[7:0]);
        put(POS_IHL, s.ver_ihl);
        put(POS_TLEN_HI, s.tlen[15:8]);
        put(POS_TLEN_LO, s.tlen[7:0]);
        put(POS_PROTO, s.proto);
        for (int k = 0; k < 4; k++) begin
            put(POS_DST_LO + k, s.dst[31 - 8 * k -: 8]);
            put(t + TCP_DPORT_END + k, s.seq[31 - 8 * k -: 8]);
            put(t + TCP_SEQ_END + k, s.ack[31 - 8 * k -: 8]);
        end
        put(t, s.sport[15:8]);
        put(t + 1, s.sport[7:0]);
        put(t + TCP_SPORT_END, s.dport[15:8]);
        put(t + TCP_SPORT_END + 1, s.dport[7:0]);
        put(t + TCP_OFFSET, s.off_byte);
        put(t + TCP_FLAGS, s.flags);
        foreach (frame_buf[i])
            drive_byte(frame_buf[i], i == s.len - 1, s.typed, s.want);
    endtask

    function automatic frame_row row(input int len, input logic [15:0] et,
                                     input logic [7:0] vi, input logic [15:0] tl,
                                     input logic [7:0] pr, input logic [31:0] dst,
                                     input logic [15:0] sp, input logic [15:0] dp,
                                     input logic [7:0] ob, input logic [7:0] fl,
                                     input bit typed, input t_reason want);
        frame_row s;
        s.len = len;     s.etype = et;   s.ver_ihl = vi;   s.tlen = tl;
        s.proto = pr;    s.dst = dst;    s.sport = sp;     s.dport = dp;
        s.seq = $urandom; s.ack = $urandom;
        s.off_byte = ob; s.flags = fl;   s.typed = typed;  s.want = want;
        return s;
    endfunction

    function automatic frame_row rand_frame(input bit clean);
        frame_row s;
        int ihl;
        int doff;
        int kind;
        ihl  = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
        doff = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : 5;
        s = row(ETH_HDR_BYTES + 4 * ihl + TCP_BASE_BYTES + $urandom_range(0, 16),
                ETHERTYPE_IPV4, {4'($urandom_range(15)), 4'(ihl)}, 16'h0, PROTO_TCP,
                cfg_ip, cfg_rport, cfg_lport, {4'(doff), 4'($urandom_range(15))},
                8'($urandom), 1'b0, RSN_OK);
        s.tlen = ($urandom_range(1) == 1) ? 16'(s.len - ETH_HDR_BYTES) : 16'($urandom);
        kind = clean ? 0 : $urandom_range(99);
        if (kind >= 90) begin
            s.len     = $urandom_range(1, 80);
            s.etype   = ($urandom_range(1) == 1) ? ETHERTYPE_IPV4 : 16'($urandom);
            s.ver_ihl = 8'($urandom);
            s.proto   = ($urandom_range(1) == 1) ? PROTO_TCP : 8'($urandom);
            s.dst     = ($urandom_range(1) == 1) ? cfg_ip : $urandom;
            s.sport   = 16'($urandom);
            s.dport   = 16'($urandom);
        end else if (kind >= 65) begin
            case ($urandom_range(7))
                0: s.etype = s.etype ^ (16'd1 << $urandom_range(15));
                1: s.proto = s.proto ^ (8'd1 << $urandom_range(7));
                2: s.dst = s.dst ^ (32'd1 << $urandom_range(31));
                3: s.ver_ihl[3:0] = 4'($urandom_range(4));
                4: s.len = (ihl > 5) ? $urandom_range(MIN_FRAME, ETH_HDR_BYTES + 4 * ihl + 19)
                                     : $urandom_range(1, MIN_FRAME - 1);
                5: s.dport = s.dport ^ (16'd1 << $urandom_range(15));
                6: s.sport = s.sport ^ (16'd1 << $urandom_range(15));
                default: s.len = $urandom_range(1, MIN_FRAME - 1);
            endcase
        end
        return s;
    endfunction

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (verdicts_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] kept;
        kept = (idx == REG_LOCAL_IP) ? val : {16'h0, val[15:0]};
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== kept)
            report_mismatch("register readback", prdata, kept);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_filter(input logic [31:0] ip, input logic [31:0] lp,
                                  input logic [31:0] rp);
        write_reg(REG_LOCAL_IP, ip);
        write_reg(REG_LOCAL_PORT, lp);
        write_reg(REG_REMOTE_PORT, rp);
        cfg_ip    = ip;
        cfg_lport = lp[15:0];
        cfg_rport = rp[15:0];
    endtask

    initial begin
        frame_row dir_rows[$];
        frame_row s;
        int       sent_bytes;
        int       frames;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: local_ip 0, local_port default, remote_port 0
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h02, 0, RSN_OK));
        dir_rows.push_back(row(53, ETHERTYPE_IPV4, 8'h45, 16'd39, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h02, 1, RSN_SHORT));
        dir_rows.push_back(row(1, 16'h0, 8'h0, 16'h0, 8'h0, 32'h0,
                               16'h0, 16'h0, 8'h0, 8'h0, 1, RSN_SHORT));
        dir_rows.push_back(row(20, 16'h0, 8'h0, 16'h0, 8'h0, 32'hFFFF_FFFF,
                               16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1, RSN_SHORT));
        dir_rows.push_back(row(54, 16'h86DD, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_NOT_IPV4));
        dir_rows.push_back(row(54, 16'h0000, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_NOT_IPV4));
        dir_rows.push_back(row(60, 16'hFFFF, 8'h45, 16'd46, 8'd17, 32'hFFFF_FFFF,
                               16'h1, 16'h0, 8'h50, 8'h10, 1, RSN_NOT_IPV4));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, 8'd17, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_NOT_TCP));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, 8'hFF, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_NOT_TCP));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'hFFFF_FFFF,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_DST_IP));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h44, 16'd40, PROTO_TCP, 32'h1,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_DST_IP));
        // header length below five words
        dir_rows.push_back(row(70, ETHERTYPE_IPV4, 8'h44, 16'd56, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_HEADER));
        dir_rows.push_back(row(70, ETHERTYPE_IPV4, 8'h40, 16'd56, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_HEADER));
        // frame ends inside the TCP header
        dir_rows.push_back(row(93, ETHERTYPE_IPV4, 8'h4F, 16'd79, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_HEADER));
        dir_rows.push_back(row(57, ETHERTYPE_IPV4, 8'h46, 16'd43, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_HEADER));
        dir_rows.push_back(row(94, ETHERTYPE_IPV4, 8'h4F, 16'd100, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h18, 0, RSN_OK));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h0, 16'h0, 8'h50, 8'h10, 1, RSN_DST_PORT));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'hFFFF, 16'hFFFF, 8'h50, 8'h10, 1, RSN_DST_PORT));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h1, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_SRC_PORT));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'hFFFF, DEFAULT_LOCAL_PORT, 8'h50, 8'h10, 1, RSN_SRC_PORT));
        // version nibble ignored, zero data offset, floored payload, full total length
        dir_rows.push_back(row(60, ETHERTYPE_IPV4, 8'hF5, 16'd46, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'hFF, 0, RSN_OK));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h0F, 8'h01, 0, RSN_OK));
        dir_rows.push_back(row(134, ETHERTYPE_IPV4, 8'h4F, 16'd10, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'hF0, 8'h00, 0, RSN_OK));
        dir_rows.push_back(row(54, ETHERTYPE_IPV4, 8'h45, 16'hFFFF, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h11, 0, RSN_OK));
        // longer than the capture window
        dir_rows.push_back(row(2050, ETHERTYPE_IPV4, 8'h45, 16'd2034, PROTO_TCP, 32'h0,
                               16'h0, DEFAULT_LOCAL_PORT, 8'h50, 8'h04, 0, RSN_OK));
        foreach (dir_rows[i])
            send_frame(dir_rows[i]);
        pause_until_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 53;
                    program_filter($urandom, $urandom, $urandom);
                end
                1: begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 6;
                    program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    program_filter(32'h0, 32'h0, 32'h0);
                end
            endcase
            sent_bytes = 0;
            frames     = 0;
            while (sent_bytes < 530) begin
                if (ph == 1 && frames == 4)
                    pause_until_drained();
                if (ph == 2 && frames == 4) begin
                    // stall the receiver and offer six clean frames so that the input backs up
                    hold_go = 1'b1;
                    repeat (6) begin
                        s = rand_frame(1'b1);
                        send_frame(s);
                        sent_bytes += s.len;
                    end
                end
                s = rand_frame(1'b0);
                send_frame(s);
                sent_bytes += s.len;
                frames++;
            end
            pause_until_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
